@@ rtl/gfba_pkg.sv @@
// Shared constants, codes and types of the grouped free-block allocator.
package gfba_pkg;

  // block numbers on the ports
  localparam int unsigned BLK_W = 10;

  // default configuration
  localparam int unsigned GROUP_SIZE_DEF  = 64;
  localparam int unsigned BLOCK_COUNT_DEF = 1024;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status codes
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_EMPTY = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SPILL,
    S_FILL,
    S_DONE
  } state_e;

  // entries of the group store: one group image per addressable block
  function automatic int unsigned store_depth(int unsigned gs, int unsigned bc);
    int unsigned nblk;
    nblk = (bc < (2 ** BLK_W)) ? bc : (2 ** BLK_W);
    return nblk * (gs + 1);
  endfunction

endpackage

@@ rtl/gfba_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
module gfba_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/gfba_ctrl.sv @@
// Allocator sequencer: group count, link, spill/refill walks and output register.
module gfba_ctrl import gfba_pkg::*; #(
  parameter int unsigned GROUP_SIZE  = GROUP_SIZE_DEF,
  parameter int unsigned BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int unsigned CNT_W       = $clog2(GROUP_SIZE + 1),
  parameter int unsigned ST_AW       = $clog2(store_depth(GROUP_SIZE, BLOCK_COUNT))
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input words
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [BLK_W-1:0] block_index_i,
  // result words
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [BLK_W-1:0] allocated_block_o,
  output logic             status_o,
  // active group RAM
  output logic             ag_we_o,
  output logic [CNT_W-1:0] ag_waddr_o,
  output logic [BLK_W-1:0] ag_wdata_o,
  output logic             ag_re_o,
  output logic [CNT_W-1:0] ag_raddr_o,
  input  logic [BLK_W-1:0] ag_rdata_i,
  // group store RAM
  output logic             st_we_o,
  output logic [ST_AW-1:0] st_waddr_o,
  output logic [BLK_W-1:0] st_wdata_o,
  output logic             st_re_o,
  output logic [ST_AW-1:0] st_raddr_o,
  input  logic [BLK_W-1:0] st_rdata_i
);

  localparam int unsigned SLOTS = GROUP_SIZE + 1;
  localparam int unsigned K_W   = $clog2(SLOTS + 1);

  localparam logic [CNT_W-1:0] CNT_ONE      = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL     = CNT_W'(GROUP_SIZE);
  localparam logic [K_W-1:0]   K_ONE        = K_W'(1);
  localparam logic [K_W-1:0]   K_LAST_SPILL = K_W'(GROUP_SIZE);
  localparam logic [K_W-1:0]   K_LAST_FILL  = K_W'(SLOTS);
  localparam logic [BLK_W-1:0] BLK_ONE      = BLK_W'(1);
  localparam logic [BLK_W-1:0] BLK_GS       = BLK_W'(GROUP_SIZE);
  localparam logic [ST_AW-1:0] ST_SLOTS     = ST_AW'(SLOTS);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BLK_W-1:0] link_q, link_d;
  logic [K_W-1:0]   k_q, k_d;
  logic [ST_AW-1:0] base_q, base_d;
  logic [BLK_W-1:0] blk_q, blk_d;
  logic [BLK_W-1:0] res_q, res_d;
  logic             stat_q, stat_d;
  logic             out_valid_q, out_valid_d;
  logic [BLK_W-1:0] out_block_q, out_block_d;
  logic             out_stat_q, out_stat_d;

  logic             in_accept;
  logic             is_alloc;
  logic             blk_ok;
  logic             link_ok;
  logic             cnt_is_one;
  logic             cnt_is_full;
  logic             out_free;
  logic [K_W-1:0]   e_idx;
  logic [CNT_W-1:0] fill_cnt;

  // request decode
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign is_alloc    = (operation_i == OP_ALLOC);
  assign blk_ok      = (block_index_i != '0) && (32'(block_index_i) < BLOCK_COUNT);
  assign link_ok     = (link_q != '0) && (32'(link_q) < BLOCK_COUNT);
  assign cnt_is_one  = (cnt_q == CNT_ONE);
  assign cnt_is_full = (cnt_q == CNT_FULL);
  assign out_free    = !out_valid_q || out_ready_i;

  // refill walk: the entry handled now was read in the previous cycle
  assign e_idx = k_q - K_ONE;

  // loaded count: zero reads as one, oversize saturates
  always_comb begin
    if (st_rdata_i == '0) begin
      fill_cnt = CNT_ONE;
    end else if (st_rdata_i > BLK_GS) begin
      fill_cnt = CNT_FULL;
    end else begin
      fill_cnt = st_rdata_i[CNT_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (is_alloc) begin
            if (!cnt_is_one) begin
              state_d = S_POP;
            end else if (link_ok) begin
              state_d = S_FILL;
            end else begin
              state_d = S_DONE;
            end
          end else if (blk_ok && cnt_is_full) begin
            state_d = S_SPILL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_POP:   state_d = S_DONE;
      S_SPILL: if (k_q == K_LAST_SPILL) state_d = S_DONE;
      S_FILL:  if (k_q == K_LAST_FILL) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_d       = cnt_q;
    link_d      = link_q;
    k_d         = k_q;
    base_d      = base_q;
    blk_d       = blk_q;
    res_d       = res_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_block_d = out_block_q;
    out_stat_d  = out_stat_q;

    ag_we_o    = 1'b0;
    ag_waddr_o = cnt_q + CNT_ONE;
    ag_wdata_o = block_index_i;
    ag_re_o    = 1'b0;
    ag_raddr_o = cnt_q;
    st_we_o    = 1'b0;
    st_waddr_o = base_q + ST_AW'(k_q);
    st_wdata_o = ag_rdata_i;
    st_re_o    = 1'b0;
    st_raddr_o = base_q + ST_AW'(k_q);

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_d  = '0;
          stat_d = STAT_OK;
          k_d    = '0;
          blk_d  = block_index_i;
          if (is_alloc) begin
            if (!cnt_is_one) begin
              // pop the top entry
              ag_re_o = 1'b1;
              cnt_d   = cnt_q - CNT_ONE;
            end else if (link_ok) begin
              // hand out the link block, then reload its group
              base_d = ST_AW'(ST_AW'(link_q) * ST_SLOTS);
              res_d  = link_q;
            end else begin
              stat_d = STAT_EMPTY;
            end
          end else if (blk_ok) begin
            if (cnt_is_full) begin
              base_d = ST_AW'(ST_AW'(block_index_i) * ST_SLOTS);
            end else begin
              ag_we_o = 1'b1;
              cnt_d   = cnt_q + CNT_ONE;
            end
          end
        end
      end
      S_POP: begin
        res_d = ag_rdata_i;
      end
      S_SPILL: begin
        // word k goes to the store; the active RAM is read one slot ahead
        st_we_o = 1'b1;
        if (k_q == '0) begin
          st_wdata_o = BLK_W'(cnt_q);
        end else if (k_q == K_ONE) begin
          st_wdata_o = link_q;
        end else begin
          st_wdata_o = ag_rdata_i;
        end
        if (k_q < K_LAST_SPILL) begin
          ag_re_o    = 1'b1;
          ag_raddr_o = CNT_W'(k_q + K_ONE);
        end
        k_d = k_q + K_ONE;
        if (k_q == K_LAST_SPILL) begin
          cnt_d  = CNT_ONE;
          link_d = blk_q;
        end
      end
      S_FILL: begin
        if (k_q <= K_LAST_SPILL) begin
          st_re_o = 1'b1;
        end
        if (k_q != '0) begin
          if (e_idx == '0) begin
            cnt_d = fill_cnt;
          end else if (e_idx == K_ONE) begin
            link_d = st_rdata_i;
          end else begin
            ag_we_o    = 1'b1;
            ag_waddr_o = CNT_W'(e_idx);
            ag_wdata_o = st_rdata_i;
          end
        end
        k_d = k_q + K_ONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_block_d = res_q;
          out_stat_d  = stat_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= CNT_ONE;
      link_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      link_q      <= link_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    blk_q       <= blk_d;
    res_q       <= res_d;
    stat_q      <= stat_d;
    out_block_q <= out_block_d;
    out_stat_q  <= out_stat_d;
  end

  assign out_valid_o       = out_valid_q;
  assign allocated_block_o = out_block_q;
  assign status_o          = out_stat_q;

  // group count always stays within 1..GROUP_SIZE
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= CNT_FULL))
    else $error("group count out of range");

  // the store is only written by a spill walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we_o |-> (state_q == S_SPILL))
    else $error("store written outside spill");

  // the active group is not modified while being spilled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SPILL) |-> !ag_we_o)
    else $error("active group written during spill");

  // a failed allocate carries block zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_EMPTY)) |-> (allocated_block_o == '0))
    else $error("failed allocate with nonzero block");

  // a spill leaves a group holding only the link to the freed block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SPILL) && (k_q == K_LAST_SPILL)) |=>
      ((cnt_q == CNT_ONE) && (link_q == blk_q)))
    else $error("spill did not restart group");

endmodule

@@ rtl/grouped_free_block_allocator_unit.sv @@
// Grouped free-block list allocator: top level with active group and group store RAMs.
// A spill or a refill walks the group one entry per cycle through one port of the store RAM.
// One word is in work at a time; the next is taken while a finished result waits.
// Reset: one used slot with link 0 (no free blocks); RAM contents need no clearing.
module grouped_free_block_allocator_unit import gfba_pkg::*; #(
  parameter int unsigned GROUP_SIZE  = GROUP_SIZE_DEF,
  parameter int unsigned BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [BLK_W-1:0] block_index_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [BLK_W-1:0] allocated_block_o,
  output logic             status_o
);

  localparam int unsigned SLOTS    = GROUP_SIZE + 1;
  localparam int unsigned CNT_W    = $clog2(SLOTS);
  localparam int unsigned ST_DEPTH = store_depth(GROUP_SIZE, BLOCK_COUNT);
  localparam int unsigned ST_AW    = $clog2(ST_DEPTH);

  logic             ag_we;
  logic [CNT_W-1:0] ag_waddr;
  logic [BLK_W-1:0] ag_wdata;
  logic             ag_re;
  logic [CNT_W-1:0] ag_raddr;
  logic [BLK_W-1:0] ag_rdata;
  logic             st_we;
  logic [ST_AW-1:0] st_waddr;
  logic [BLK_W-1:0] st_wdata;
  logic             st_re;
  logic [ST_AW-1:0] st_raddr;
  logic [BLK_W-1:0] st_rdata;

  // sequencer
  gfba_ctrl #(
    .GROUP_SIZE  (GROUP_SIZE),
    .BLOCK_COUNT (BLOCK_COUNT),
    .CNT_W       (CNT_W),
    .ST_AW       (ST_AW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .block_index_i     (block_index_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .allocated_block_o (allocated_block_o),
    .status_o          (status_o),
    .ag_we_o           (ag_we),
    .ag_waddr_o        (ag_waddr),
    .ag_wdata_o        (ag_wdata),
    .ag_re_o           (ag_re),
    .ag_raddr_o        (ag_raddr),
    .ag_rdata_i        (ag_rdata),
    .st_we_o           (st_we),
    .st_waddr_o        (st_waddr),
    .st_wdata_o        (st_wdata),
    .st_re_o           (st_re),
    .st_raddr_o        (st_raddr),
    .st_rdata_i        (st_rdata)
  );

  // active group slots
  gfba_ram #(
    .DEPTH (SLOTS),
    .AW    (CNT_W),
    .DW    (BLK_W)
  ) u_active_ram (
    .clk_i   (clk_i),
    .we_i    (ag_we),
    .waddr_i (ag_waddr),
    .wdata_i (ag_wdata),
    .re_i    (ag_re),
    .raddr_i (ag_raddr),
    .rdata_o (ag_rdata)
  );

  // spilled group images, one per block
  gfba_ram #(
    .DEPTH (ST_DEPTH),
    .AW    (ST_AW),
    .DW    (BLK_W)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

endmodule

@@ bench/gfba_alloc_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the grouped free-block allocator: tracks the free list and checks every reply.
module gfba_alloc_checker import gfba_pkg::*; #(
  parameter int unsigned GROUP_SIZE  = GROUP_SIZE_DEF,
  parameter int unsigned BLOCK_COUNT = BLOCK_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             operation_i,
  input  logic [BLK_W-1:0] block_index_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [BLK_W-1:0] allocated_block_i,
  input  logic             status_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      pending_count_o,
  output int unsigned      words_in_o,
  output int unsigned      spill_count_o,
  output int unsigned      refill_count_o,
  output int unsigned      empty_count_o,
  output int unsigned      ignored_count_o
);

  localparam int unsigned SLOTS        = GROUP_SIZE + 1;
  localparam int unsigned IMAGE_BLOCKS = (BLOCK_COUNT < 2 ** BLK_W) ? BLOCK_COUNT : 2 ** BLK_W;

  typedef struct packed {
    logic [BLK_W-1:0] block;
    logic             status;
  } alloc_reply_t;

  // shadow copy of the free list
  int unsigned      used_slots;
  logic [BLK_W-1:0] group_regs   [1:GROUP_SIZE];
  logic [BLK_W-1:0] group_images [IMAGE_BLOCKS*SLOTS];
  alloc_reply_t     replies_due  [$];

  // apply one word to the shadow list and return the reply it should produce
  function automatic alloc_reply_t serve_word(logic op, logic [BLK_W-1:0] blk);
    alloc_reply_t     reply;
    int unsigned      base;
    int unsigned      cnt;
    logic [BLK_W-1:0] link;
    reply.block  = '0;
    reply.status = STAT_OK;
    if (op == OP_ALLOC) begin
      if (used_slots == 1) begin
        link = group_regs[1];
        if (link == '0 || link >= BLOCK_COUNT) begin
          reply.status = STAT_EMPTY;
          empty_count_o++;
        end else begin
          // refill: pull the linked group in and hand out the link block
          base = link * SLOTS;
          cnt  = group_images[base];
          if (cnt == 0) cnt = 1;
          if (cnt > GROUP_SIZE) cnt = GROUP_SIZE;
          for (int s = 1; s <= GROUP_SIZE; s++) group_regs[s] = group_images[base + s];
          used_slots  = cnt;
          reply.block = link;
          refill_count_o++;
        end
      end else begin
        reply.block = group_regs[used_slots];
        used_slots--;
      end
    end else if (blk != '0 && blk < BLOCK_COUNT) begin
      if (used_slots == GROUP_SIZE) begin
        // spill: full group goes into the freed block, which becomes the new link
        base = blk * SLOTS;
        group_images[base] = BLK_W'(used_slots);
        for (int s = 1; s <= GROUP_SIZE; s++) group_images[base + s] = group_regs[s];
        used_slots    = 1;
        group_regs[1] = blk;
        spill_count_o++;
      end else begin
        used_slots++;
        group_regs[used_slots] = blk;
      end
    end else begin
      ignored_count_o++;
    end
    return reply;
  endfunction

  task automatic note_mismatch(string what, int unsigned exp_val, int unsigned act_val);
    mismatch_count_o++;
    if (mismatch_count_o <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_val, act_val);
  endtask

  // compare replies first, then predict for the word taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_reply_t due;
    if (!rst_ni) begin
      used_slots = 1;
      for (int s = 1; s <= GROUP_SIZE; s++) group_regs[s] = '0;
      replies_due.delete();
      mismatch_count_o = 0;
      words_in_o       = 0;
      spill_count_o    = 0;
      refill_count_o   = 0;
      empty_count_o    = 0;
      ignored_count_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          note_mismatch("unexpected word, block", 0, allocated_block_i);
        end else begin
          due = replies_due.pop_front();
          if (allocated_block_i !== due.block)
            note_mismatch("allocated_block", due.block, allocated_block_i);
          if (status_i !== due.status)
            note_mismatch("status", due.status, status_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        replies_due.push_back(serve_word(operation_i, block_index_i));
        words_in_o++;
      end
    end
    pending_count_o = replies_due.size();
  end

endmodule

@@ bench/grouped_free_block_allocator_unit_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the grouped free-block allocator: stimulus, flow control and verdict.
module grouped_free_block_allocator_unit_test import gfba_pkg::*;;

  localparam int unsigned TARGET_WORDS = 700;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_CYCLES = 2 * (GROUP_SIZE_DEF + 4) + 20;
  localparam int unsigned HOLD_CYCLES  = 600;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             operation_i   = OP_ALLOC;
  logic [BLK_W-1:0] block_index_i = '0;
  logic             out_ready_i   = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [BLK_W-1:0] allocated_block_o;
  logic             status_o;

  int unsigned mismatches, pending, words_in, spills, refills, empties, ignored;
  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;
  logic        sink_hold   = 1'b0;
  bit          source_eager = 1'b0;

  always #2 clk_i = ~clk_i;

  grouped_free_block_allocator_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .block_index_i    (block_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .allocated_block_o(allocated_block_o),
    .status_o         (status_o)
  );

  gfba_alloc_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .operation_i      (operation_i),
    .block_index_i    (block_index_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .allocated_block_i(allocated_block_o),
    .status_i         (status_o),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending),
    .words_in_o       (words_in),
    .spill_count_o    (spills),
    .refill_count_o   (refills),
    .empty_count_o    (empties),
    .ignored_count_o  (ignored)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // random block number, block zero now and then
  function automatic logic [BLK_W-1:0] pick_block();
    if ($urandom_range(0, 31) == 0) return '0;
    return BLK_W'($urandom_range(1, 2 ** BLK_W - 1));
  endfunction

  // offer one word and wait until the block takes it
  task automatic send_word(logic op, logic [BLK_W-1:0] blk);
    int unsigned gap;
    gap = source_eager ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    block_index_i <= blk;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // result side: random stalls, eager stretches, and the long hold-off
  initial begin : sink
    int unsigned gap;
    int unsigned taken;
    bit          sink_eager;
    taken      = 0;
    sink_eager = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) sink_eager = ($urandom_range(0, 2) == 0);
      gap = sink_eager ? 0 : $urandom_range(0, 9);
      if (gap > 0 || sink_hold) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (sink_hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // back up the pipe once while words keep coming
  initial begin
    wait (words_sent >= 250);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  initial begin : stimulus
    int unsigned run;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pool, block zero, extreme blocks, double free
    send_word(OP_ALLOC, '1);
    send_word(OP_FREE, '0);
    send_word(OP_FREE, '1);
    send_word(OP_FREE, BLK_W'(1));
    send_word(OP_ALLOC, '0);
    send_word(OP_ALLOC, '0);
    send_word(OP_ALLOC, '0);
    send_word(OP_FREE, BLK_W'('h2AA));
    send_word(OP_FREE, BLK_W'('h155));
    send_word(OP_FREE, BLK_W'('h200));
    send_word(OP_ALLOC, '1);
    send_word(OP_ALLOC, '0);
    send_word(OP_FREE, BLK_W'(7));
    send_word(OP_FREE, BLK_W'(7));
    send_word(OP_ALLOC, '0);
    send_word(OP_ALLOC, '0);
    send_word(OP_ALLOC, '0);
    send_word(OP_ALLOC, '0);

    // random: long free runs force spills, long allocate runs force refills and empties
    while (words_sent < TARGET_WORDS) begin
      source_eager = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          run = $urandom_range(40, 140);
          if (run > TARGET_WORDS - words_sent) run = TARGET_WORDS - words_sent;
          repeat (run) send_word(OP_FREE, pick_block());
        end
        4, 5, 6: begin
          run = $urandom_range(40, 200);
          if (run > TARGET_WORDS - words_sent) run = TARGET_WORDS - words_sent;
          repeat (run) send_word(OP_ALLOC, BLK_W'($urandom));
        end
        default: begin
          run = $urandom_range(1, 60);
          if (run > TARGET_WORDS - words_sent) run = TARGET_WORDS - words_sent;
          repeat (run) send_word(($urandom_range(0, 1) == 1) ? OP_FREE : OP_ALLOC, pick_block());
        end
      endcase
    end
    in_valid_i <= 1'b0;

    // drain, then give stray replies a chance to show up
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d words: %0d spills, %0d refills, %0d empty allocates, %0d ignored frees",
             words_in, spills, refills, empties, ignored);
    $display("%0d mismatches over %0d cycles", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
